[rtl/rotation_matrix_to_quaternion_macros.svh]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: assertion macros
// Concurrent assertion forms used by the queue RTL file.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RMQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Types and fixed constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Magnitude width of one unnormalized quaternion component.
    localparam int MAG_W = 31;
    localparam int LANES = 4;

    // Leading component chosen by the front end.
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_W = 2'd0;
    localparam t_cls CLS_X = 2'd1;
    localparam t_cls CLS_Y = 2'd2;
    localparam t_cls CLS_Z = 2'd3;

    // One classified item: signs and magnitudes of (w, x, y, z).
    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } t_item;

    // Queue status seen by the other parts.
    typedef struct packed {
        logic empty;
        logic almost_full;
    } t_q_stat;

endpackage

[rtl/rmq_front.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front end
// Classifies a matrix by trace and diagonal, then forms the integer vector.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_push,
    output rmq_pkg::t_item     o_item
);
    import rmq_pkg::*;

    localparam int VW = 33;

    logic signed [15:0] r_m [0:8];
    t_cls               r_cls;
    logic               r_v1;
    t_item              r_item;
    logic               r_v2;

    logic signed [17:0] trace;
    t_cls               n_cls;
    logic signed [VW-1:0] e [0:8];
    logic signed [VW-1:0] one;
    logic signed [VW-1:0] rad;
    logic signed [VW-1:0] v [0:3];
    t_item              n_item;

    // Classification: trace sign, then largest diagonal with lower index on ties.
    always_comb begin
        trace = 18'(i_m00) + 18'(i_m11) + 18'(i_m22);
        if (trace > 18'sd0) begin
            n_cls = CLS_W;
        end else if (i_m22 > ((i_m11 > i_m00) ? i_m11 : i_m00)) begin
            n_cls = CLS_Z;
        end else if (i_m11 > i_m00) begin
            n_cls = CLS_Y;
        end else begin
            n_cls = CLS_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_take;
        end
        if (i_take) begin
            r_m[0] <= i_m00; r_m[1] <= i_m01; r_m[2] <= i_m02;
            r_m[3] <= i_m10; r_m[4] <= i_m11; r_m[5] <= i_m12;
            r_m[6] <= i_m20; r_m[7] <= i_m21; r_m[8] <= i_m22;
            r_cls  <= n_cls;
        end
    end

    // Unnormalized vector: radicand on the leading component, sums and
    // differences of off-diagonal pairs elsewhere.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            e[i] = VW'(r_m[i]);
        end
        one = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;
        rad = '0;
        for (int i = 0; i < 4; i++) begin
            v[i] = '0;
        end
        case (r_cls)
            CLS_W: begin
                rad  = e[0] + e[4] + e[8] + one;
                v[1] = e[7] - e[5];
                v[2] = e[2] - e[6];
                v[3] = e[3] - e[1];
            end
            CLS_X: begin
                rad  = e[0] - e[4] - e[8] + one;
                v[0] = e[7] - e[5];
                v[2] = e[3] + e[1];
                v[3] = e[6] + e[2];
            end
            CLS_Y: begin
                rad  = e[4] - e[8] - e[0] + one;
                v[0] = e[2] - e[6];
                v[3] = e[7] + e[5];
                v[1] = e[1] + e[3];
            end
            default: begin
                rad  = e[8] - e[0] - e[4] + one;
                v[0] = e[3] - e[1];
                v[1] = e[2] + e[6];
                v[2] = e[5] + e[7];
            end
        endcase
        // A radicand at or below zero is held at one LSB.
        if (rad <= 0) begin
            rad = {{(VW-1){1'b0}}, 1'b1};
        end
        case (r_cls)
            CLS_W:   v[0] = rad;
            CLS_X:   v[1] = rad;
            CLS_Y:   v[2] = rad;
            default: v[3] = rad;
        endcase
        for (int i = 0; i < 4; i++) begin
            n_item.neg[i] = v[i][VW-1];
            n_item.mag[i] = v[i][VW-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        if (r_v1) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_v2;
    assign o_item = r_item;

endmodule

[rtl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rmq_pkg::t_item    i_item,
    input  logic              i_pop,
    output rmq_pkg::t_item    o_item,
    output rmq_pkg::t_q_stat  o_stat
);
    import rmq_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_item         r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_cnt;
    logic [PW:0]   n_cnt;

    // Occupancy follows the push and pop transfers.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Two entries stay free for the items inside the front end.
    assign o_item             = r_mem[r_rptr];
    assign o_stat.empty       = (r_cnt == '0);
    assign o_stat.almost_full = (r_cnt >= (PW+1)'(DEPTH - 2));

    `RMQ_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !i_pop && r_cnt == (PW+1)'(DEPTH)), "queue overflow")
    `RMQ_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && r_cnt == '0), "queue underflow")
    `RMQ_ASSERT_NEXT(a_cnt_push, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "count did not grow on push")

endmodule

[rtl/rmq_back.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: back end
// Normalizes the integer vector: scale, square sum, root and four quotients.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rmq_pkg::t_item     i_item,
    output logic               o_done,
    output logic signed [15:0] o_quat [0:3]
);
    import rmq_pkg::*;

    localparam int SH_N = 5;             // scaling stages: 16, 8, 4, 2, 1
    localparam int RT_N = 32;            // root stages, one bit each
    localparam int QW   = FRAC_BITS + 1; // quotient bits
    localparam int DW   = 33 + FRAC_BITS;

    // Scaling pipeline.
    logic [MAG_W-1:0] r_sm   [0:SH_N][0:3];
    logic [MAG_W-1:0] r_smax [0:SH_N];
    logic [3:0]       r_sneg [0:SH_N];
    logic             r_sv   [0:SH_N];
    logic [MAG_W-1:0] n_sm   [1:SH_N][0:3];
    logic [MAG_W-1:0] n_smax [1:SH_N];
    logic [MAG_W-1:0] in_max;

    // Square and sum.
    logic [2*MAG_W-1:0] r_sq [0:3];
    logic [2*MAG_W:0]   r_s01;
    logic [2*MAG_W:0]   r_s23;
    logic [63:0]        r_n2;
    logic [MAG_W-1:0]   r_qm [0:1][0:3];
    logic [3:0]         r_qn [0:1];
    logic               r_qv [0:1];
    logic [MAG_W-1:0]   r_pm [0:3];
    logic [3:0]         r_pn;
    logic               r_pv;

    // Root pipeline.
    logic [63:0]      r_rem [0:RT_N];
    logic [63:0]      r_res [0:RT_N];
    logic [MAG_W-1:0] r_rm  [0:RT_N][0:3];
    logic [3:0]       r_rn  [0:RT_N];
    logic             r_rv  [0:RT_N];
    logic [63:0]      n_rem [1:RT_N];
    logic [63:0]      n_res [1:RT_N];

    // Division pipeline, four lanes.
    logic [DW-1:0] r_drem [0:QW][0:3];
    logic [QW-1:0] r_dq   [0:QW][0:3];
    logic [31:0]   r_dnrm [0:QW];
    logic [3:0]    r_dn   [0:QW];
    logic          r_dv   [0:QW];
    logic [DW-1:0] n_drem [1:QW][0:3];
    logic [QW-1:0] n_dq   [1:QW][0:3];
    logic [DW-1:0] d_den  [1:QW];
    logic [DW-1:0] d_num  [0:3];

    // Output.
    logic               r_done;
    logic signed [15:0] r_quat [0:3];
    logic signed [15:0] n_quat [0:3];
    logic [31:0]        qz     [0:3];
    logic signed [16:0] sq     [0:3];

    // Largest magnitude of the incoming item.
    always_comb begin
        in_max = i_item.mag[0];
        for (int t = 1; t < 4; t++) begin
            if (i_item.mag[t] > in_max) begin
                in_max = i_item.mag[t];
            end
        end
    end

    // Each scaling stage shifts all lanes when the largest still fits.
    always_comb begin
        for (int s = 1; s <= SH_N; s++) begin
            n_smax[s] = r_smax[s-1];
            for (int t = 0; t < 4; t++) begin
                n_sm[s][t] = r_sm[s-1][t];
            end
            if (r_smax[s-1] < (MAG_W'(1) << (MAG_W - (1 << (SH_N - s))))) begin
                n_smax[s] = r_smax[s-1] << (1 << (SH_N - s));
                for (int t = 0; t < 4; t++) begin
                    n_sm[s][t] = r_sm[s-1][t] << (1 << (SH_N - s));
                end
            end
        end
    end

    // Integer root, one result bit per stage.
    always_comb begin
        for (int s = 1; s <= RT_N; s++) begin
            if (r_rem[s-1] >= r_res[s-1] + (64'd1 << (64 - 2*s))) begin
                n_rem[s] = r_rem[s-1] - (r_res[s-1] + (64'd1 << (64 - 2*s)));
                n_res[s] = (r_res[s-1] >> 1) + (64'd1 << (64 - 2*s));
            end else begin
                n_rem[s] = r_rem[s-1];
                n_res[s] = r_res[s-1] >> 1;
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            d_num[t] = (DW'(r_rm[RT_N][t]) << FRAC_BITS) + DW'(r_res[RT_N][31:1]);
        end
        for (int s = 1; s <= QW; s++) begin
            d_den[s] = DW'(r_dnrm[s-1]) << (QW - s);
            for (int t = 0; t < 4; t++) begin
                if (r_drem[s-1][t] >= d_den[s]) begin
                    n_drem[s][t] = r_drem[s-1][t] - d_den[s];
                    n_dq[s][t]   = {r_dq[s-1][t][QW-2:0], 1'b1};
                end else begin
                    n_drem[s][t] = r_drem[s-1][t];
                    n_dq[s][t]   = {r_dq[s-1][t][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Saturation and sign of each output.
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            qz[t] = 32'(r_dq[QW][t]);
            if (qz[t] > 32'd32768) begin
                qz[t] = 32'd32768;
            end
            sq[t] = r_dn[QW][t] ? -$signed(qz[t][16:0]) : $signed(qz[t][16:0]);
            if (sq[t] > 17'sd32767) begin
                sq[t] = 17'sd32767;
            end
            n_quat[t] = sq[t][15:0];
        end
    end

    // Valid bits along the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SH_N; s++) r_sv[s] <= 1'b0;
            for (int s = 0; s <= 1; s++) r_qv[s] <= 1'b0;
            r_pv <= 1'b0;
            for (int s = 0; s <= RT_N; s++) r_rv[s] <= 1'b0;
            for (int s = 0; s <= QW; s++) r_dv[s] <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_sv[0] <= i_valid;
            for (int s = 1; s <= SH_N; s++) r_sv[s] <= r_sv[s-1];
            r_pv    <= r_sv[SH_N];
            r_qv[0] <= r_pv;
            r_qv[1] <= r_qv[0];
            r_rv[0] <= r_qv[1];
            for (int s = 1; s <= RT_N; s++) r_rv[s] <= r_rv[s-1];
            r_dv[0] <= r_rv[RT_N];
            for (int s = 1; s <= QW; s++) r_dv[s] <= r_dv[s-1];
            r_done <= r_dv[QW];
        end
    end

    // Payload along the pipeline.
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < 4; t++) r_sm[0][t] <= i_item.mag[t];
        r_smax[0] <= in_max;
        r_sneg[0] <= i_item.neg;
        for (int s = 1; s <= SH_N; s++) begin
            r_smax[s] <= n_smax[s];
            r_sneg[s] <= r_sneg[s-1];
            for (int t = 0; t < 4; t++) r_sm[s][t] <= n_sm[s][t];
        end

        for (int t = 0; t < 4; t++) begin
            r_sq[t] <= r_sm[SH_N][t] * r_sm[SH_N][t];
            r_pm[t] <= r_sm[SH_N][t];
        end
        r_pn <= r_sneg[SH_N];

        r_s01 <= (2*MAG_W+1)'(r_sq[0]) + (2*MAG_W+1)'(r_sq[1]);
        r_s23 <= (2*MAG_W+1)'(r_sq[2]) + (2*MAG_W+1)'(r_sq[3]);
        r_qn[0] <= r_pn;
        for (int t = 0; t < 4; t++) r_qm[0][t] <= r_pm[t];
        r_n2 <= 64'(r_s01) + 64'(r_s23);
        r_qn[1] <= r_qn[0];
        for (int t = 0; t < 4; t++) r_qm[1][t] <= r_qm[0][t];

        r_rem[0] <= r_n2;
        r_res[0] <= '0;
        r_rn[0]  <= r_qn[1];
        for (int t = 0; t < 4; t++) r_rm[0][t] <= r_qm[1][t];
        for (int s = 1; s <= RT_N; s++) begin
            r_rem[s] <= n_rem[s];
            r_res[s] <= n_res[s];
            r_rn[s]  <= r_rn[s-1];
            for (int t = 0; t < 4; t++) r_rm[s][t] <= r_rm[s-1][t];
        end

        // The root is at least 2^30 after scaling, so it is never zero.
        r_dnrm[0] <= r_res[RT_N][31:0];
        r_dn[0]   <= r_rn[RT_N];
        for (int t = 0; t < 4; t++) begin
            r_drem[0][t] <= d_num[t];
            r_dq[0][t]   <= '0;
        end
        for (int s = 1; s <= QW; s++) begin
            r_dnrm[s] <= r_dnrm[s-1];
            r_dn[s]   <= r_dn[s-1];
            for (int t = 0; t < 4; t++) begin
                r_drem[s][t] <= n_drem[s][t];
                r_dq[s][t]   <= n_dq[s][t];
            end
        end

        for (int t = 0; t < 4; t++) r_quat[t] <= n_quat[t];
    end

    assign o_done = r_done;
    assign o_quat = r_quat;

endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Converts a 3x3 rotation matrix to a unit quaternion by Shoemake's method.
//
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    i_m00 .. i_m22
// result    out        o_done strobe           o_quat_w, o_quat_x, o_quat_y, o_quat_z
//
// One matrix is taken per cycle while busy is low; each result passes through the
// 32-stage root and the FRAC_BITS+1 stage divider.
// Synchronous active-low reset clears only valid bits, queue pointers and count.
// The receiver cannot stall; busy rises only when the queue between the classifier
// and normalizer holds two or more items, which the free-running back end prevents.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_done,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);
    import rmq_pkg::*;

    logic               take;
    logic               push;
    t_item              f_item;
    t_item              q_item;
    t_q_stat            q_stat;
    logic signed [15:0] quat [0:3];

    // A command transfer happens when start meets a free queue.
    assign busy = q_stat.almost_full;
    assign take = start && !busy;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_m00   (i_m00), .i_m01 (i_m01), .i_m02 (i_m02),
        .i_m10   (i_m10), .i_m11 (i_m11), .i_m12 (i_m12),
        .i_m20   (i_m20), .i_m21 (i_m21), .i_m22 (i_m22),
        .o_push  (push),
        .o_item  (f_item)
    );

    rmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (!q_stat.empty),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // The back end drains the queue whenever it holds an item.
    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_stat.empty),
        .i_item  (q_item),
        .o_done  (o_done),
        .o_quat  (quat)
    );

    assign o_quat_w = quat[0];
    assign o_quat_x = quat[1];
    assign o_quat_y = quat[2];
    assign o_quat_z = quat[3];

endmodule
